// ===== rtl/chw_pkg.sv =====
package chw_pkg;

  // Fixed row offset and size limits
  localparam int ROW_START  = 0;
  localparam int MAX_PULSES = 8;
  localparam int MAX_WIDTH  = 8;

  // Hue offset divider: dividend is hue_spread * 16 (4.12 turns -> 0.16 turns)
  localparam int DIV_W     = 20;
  localparam int DIV_CNT_W = 5;

  // Colour wheel segment bounds
  localparam logic [7:0] WHEEL_SEG1 = 8'd85;
  localparam logic [7:0] WHEEL_SEG2 = 8'd170;
  localparam logic [7:0] WHEEL_MAX  = 8'd255;

  // Register indexes
  localparam logic [2:0] REG_ROW_LENGTH  = 3'd0;
  localparam logic [2:0] REG_PULSE_COUNT = 3'd1;
  localparam logic [2:0] REG_PULSE_WIDTH = 3'd2;
  localparam logic [2:0] REG_REVERSE     = 3'd3;
  localparam logic [2:0] REG_START_HUE   = 3'd4;
  localparam logic [2:0] REG_COLOR_COUNT = 3'd5;
  localparam logic [2:0] REG_HUE_SPREAD  = 3'd6;
  localparam logic [2:0] REG_BRIGHTNESS  = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_RUN
  } seq_state_e;

  // Configuration as seen by the datapath; counts already saturated
  typedef struct packed {
    logic [7:0]  row_length;
    logic [3:0]  pulse_count;
    logic [3:0]  pulse_width;
    logic        reverse;
    logic [15:0] start_hue;
    logic [7:0]  color_count;
    logic [15:0] hue_spread;
    logic [7:0]  brightness;
  } cfg_t;

  // One pixel job from the sequencer
  typedef struct packed {
    logic        valid;
    logic [2:0]  pulse;
    logic [7:0]  pos;
    logic [15:0] hue_off;
    logic        last;
  } tok_t;

  // ceil(2^16 / count): x / (2*count) == (x * recip) >> 17 for x < 4096
  function automatic logic [16:0] pulse_recip(logic [3:0] cnt);
    logic [16:0] r;
    unique case (cnt)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  // Three-segment rainbow, first component in the low byte
  function automatic logic [23:0] wheel(logic [7:0] x);
    logic [7:0] y;
    logic [7:0] t;
    logic [23:0] c;
    if (x < WHEEL_SEG1) begin
      y = x;
    end else if (x < WHEEL_SEG2) begin
      y = x - WHEEL_SEG1;
    end else begin
      y = x - WHEEL_SEG2;
    end
    t = y + {y[6:0], 1'b0};
    if (x < WHEEL_SEG1) begin
      c = {t, 8'h00, WHEEL_MAX - t};
    end else if (x < WHEEL_SEG2) begin
      c = {WHEEL_MAX - t, t, 8'h00};
    end else begin
      c = {8'h00, WHEEL_MAX - t, t};
    end
    return c;
  endfunction

endpackage

// ===== rtl/led_pulse_color_wheel_pattern.sv =====
// Colour wheel pulse chaser for a circular LED row.
// Input channel (in_valid_i / in_stall_o / progress_i): one beat is an
// animation position, 0.16 fraction of the row. Each beat expands into
// pulse_count * pulse_width pixel writes (up to 64) on the output channel
// (out_valid_o / out_stall_i / pixel_*_o / last_o), pulse by pulse, pixel by
// pixel; last_o marks the final write. Empty rows, zero pulses or zero width
// swallow the beat and produce nothing.
// Config channel (cfg_valid_i / cfg_ready_o, always ready): write only while
// the block is idle.
// Sequence: after an input beat the sequencer computes the start pixel in
// ST_LOAD; with color_count above 1 a bit-serial divider then sets up the
// hue step in ST_DIV. Writes are then issued one per cycle, unless the output
// stalls, into a three-stage pipeline; each write passes stage 1, stage 2 and
// the stage 3 output register. The next input beat is taken once the last
// write is issued.
// An output stall freezes the whole pipeline and any write issue; nothing is
// lost or repeated. Reset empties the pipeline and restores default registers.
module led_pulse_color_wheel_pattern (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] progress_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [8:0]  pixel_index_o,
  output logic [23:0] pixel_color_o,
  output logic [7:0]  pixel_brightness_o,
  output logic        last_o
);

  logic [7:0]  row_length_q;
  logic [3:0]  pulse_count_q;
  logic [3:0]  pulse_width_q;
  logic        reverse_q;
  logic [15:0] start_hue_q;
  logic [7:0]  color_count_q;
  logic [15:0] hue_spread_q;
  logic [7:0]  brightness_q;

  chw_pkg::cfg_t cfg;
  chw_pkg::tok_t tok;
  logic          adv;

  assign cfg_ready_o = 1'b1;

  // Register file, written a beat at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q  <= 8'd60;
      pulse_count_q <= 4'd1;
      pulse_width_q <= 4'd1;
      reverse_q     <= 1'b0;
      start_hue_q   <= 16'd0;
      color_count_q <= 8'd1;
      hue_spread_q  <= 16'd0;
      brightness_q  <= 8'd255;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        chw_pkg::REG_ROW_LENGTH:  row_length_q  <= cfg_data_i[7:0];
        chw_pkg::REG_PULSE_COUNT: pulse_count_q <= cfg_data_i[3:0];
        chw_pkg::REG_PULSE_WIDTH: pulse_width_q <= cfg_data_i[3:0];
        chw_pkg::REG_REVERSE:     reverse_q     <= cfg_data_i[0];
        chw_pkg::REG_START_HUE:   start_hue_q   <= cfg_data_i;
        chw_pkg::REG_COLOR_COUNT: color_count_q <= cfg_data_i[7:0];
        chw_pkg::REG_HUE_SPREAD:  hue_spread_q  <= cfg_data_i;
        chw_pkg::REG_BRIGHTNESS:  brightness_q  <= cfg_data_i[7:0];
      endcase
    end
  end

  // Counts clamp to the pulse and width limits
  always_comb begin
    cfg.row_length  = row_length_q;
    cfg.pulse_count = (pulse_count_q > 4'(chw_pkg::MAX_PULSES)) ?
                      4'(chw_pkg::MAX_PULSES) : pulse_count_q;
    cfg.pulse_width = (pulse_width_q > 4'(chw_pkg::MAX_WIDTH)) ?
                      4'(chw_pkg::MAX_WIDTH) : pulse_width_q;
    cfg.reverse     = reverse_q;
    cfg.start_hue   = start_hue_q;
    cfg.color_count = color_count_q;
    cfg.hue_spread  = hue_spread_q;
    cfg.brightness  = brightness_q;
  end

  // Sequencer walks pulses and pixels, one job per cycle while the pipeline advances
  chw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .progress_i (progress_i),
    .adv_i      (adv),
    .tok_o      (tok)
  );

  // Shift, wrap, mirror and colour over three stages
  chw_pipe u_pipe (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .tok_i              (tok),
    .adv_o              (adv),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pixel_index_o      (pixel_index_o),
    .pixel_color_o      (pixel_color_o),
    .pixel_brightness_o (pixel_brightness_o),
    .last_o             (last_o)
  );

endmodule

// ===== rtl/chw_div.sv =====
module chw_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [chw_pkg::DIV_W-1:0]  dividend_i,
  input  logic [7:0]                 divisor_i,
  output logic                       busy_o,
  output logic [chw_pkg::DIV_W-1:0]  quo_o,
  output logic [7:0]                 rem_o
);

  logic [chw_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [chw_pkg::DIV_W-1:0]     quo_q, quo_d;
  logic [7:0]                    rem_q, rem_d;
  logic [7:0]                    dvs_q, dvs_d;
  logic [8:0]                    trial;
  logic                          ge;

  // Restoring division, one quotient bit a cycle
  always_comb begin
    trial = {rem_q, quo_q[chw_pkg::DIV_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = chw_pkg::DIV_CNT_W'(chw_pkg::DIV_W);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[chw_pkg::DIV_W-2:0], ge};
      rem_d = ge ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/chw_seq.sv =====
module chw_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chw_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [15:0]      progress_i,
  input  logic             adv_i,
  output chw_pkg::tok_t    tok_o
);

  chw_pkg::seq_state_e state_q, state_d;

  logic [15:0] progress_q;
  logic [7:0]  base_q;
  logic [2:0]  j_q;
  logic [2:0]  i_q;
  logic [2:0]  k_q;
  logic [7:0]  p_q;
  logic [15:0] off_q;
  logic [7:0]  r_q;

  logic                       div_start;
  logic                       div_busy;
  logic [chw_pkg::DIV_W-1:0]  div_quo;
  logic [7:0]                 div_rem;
  logic [7:0]                 div_dvs;

  logic        accept;
  logic        empty_job;
  logic        multi_col;
  logic        last_pix;
  logic        last_pulse;
  logic        issue;
  logic [23:0] base_prod;
  logic [8:0]  r_sum;
  logic        r_carry;

  assign div_dvs   = cfg_i.color_count - 8'd1;
  assign multi_col = cfg_i.color_count > 8'd1;
  assign empty_job = (cfg_i.row_length == '0) || (cfg_i.pulse_count == '0) ||
                     (cfg_i.pulse_width == '0);
  assign accept    = in_valid_i && !in_stall_o;
  assign last_pix   = {1'b0, i_q} == (cfg_i.pulse_width - 4'd1);
  assign last_pulse = {1'b0, j_q} == (cfg_i.pulse_count - 4'd1);
  assign issue      = (state_q == chw_pkg::ST_RUN) && adv_i;
  assign base_prod  = progress_q * {16'd0, cfg_i.row_length};
  assign r_sum      = {1'b0, r_q} + {1'b0, div_rem};
  assign r_carry    = r_sum >= {1'b0, div_dvs};

  chw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({cfg_i.hue_spread, 4'd0}),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chw_pkg::ST_IDLE: begin
        if (accept && !empty_job) state_d = chw_pkg::ST_LOAD;
      end
      chw_pkg::ST_LOAD: begin
        state_d = multi_col ? chw_pkg::ST_DIV : chw_pkg::ST_RUN;
      end
      chw_pkg::ST_DIV: begin
        if (!div_busy) state_d = chw_pkg::ST_RUN;
      end
      chw_pkg::ST_RUN: begin
        if (issue && last_pix && last_pulse) state_d = chw_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o    = state_q != chw_pkg::ST_IDLE;
    div_start     = (state_q == chw_pkg::ST_LOAD) && multi_col;
    tok_o.valid   = state_q == chw_pkg::ST_RUN;
    tok_o.pulse   = j_q;
    tok_o.pos     = p_q;
    tok_o.hue_off = off_q;
    tok_o.last    = last_pix && last_pulse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pixel and pulse counters; offset tracks floor(k*S/D) as k steps
  always_ff @(posedge clk_i) begin
    if (accept) begin
      progress_q <= progress_i;
    end
    if (state_q == chw_pkg::ST_LOAD) begin
      base_q <= base_prod[23:16];
      p_q    <= base_prod[23:16];
      j_q    <= '0;
      i_q    <= '0;
      k_q    <= '0;
      off_q  <= '0;
      r_q    <= '0;
    end else if (issue) begin
      if (last_pix) begin
        i_q <= '0;
        p_q <= base_q;
        j_q <= j_q + 3'd1;
        if (!multi_col || ({5'd0, k_q} + 8'd1 == cfg_i.color_count)) begin
          k_q   <= '0;
          off_q <= '0;
          r_q   <= '0;
        end else begin
          k_q   <= k_q + 3'd1;
          off_q <= off_q + div_quo[15:0] + {15'd0, r_carry};
          r_q   <= r_carry ? 8'(r_sum - {1'b0, div_dvs}) : r_sum[7:0];
        end
      end else begin
        i_q <= i_q + 3'd1;
        p_q <= ({1'b0, p_q} + 9'd1 == {1'b0, cfg_i.row_length}) ? 8'd0 : p_q + 8'd1;
      end
    end
  end

endmodule

// ===== rtl/chw_pipe.sv =====
module chw_pipe (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chw_pkg::cfg_t    cfg_i,
  input  chw_pkg::tok_t    tok_i,
  output logic             adv_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [8:0]       pixel_index_o,
  output logic [23:0]      pixel_color_o,
  output logic [7:0]       pixel_brightness_o,
  output logic             last_o
);

  logic        v1_q, v2_q, v3_q;
  // stage 1
  logic [11:0] num1_q;
  logic [15:0] hue1_q;
  logic [7:0]  p1_q;
  logic        last1_q;
  // stage 2
  logic [28:0] prod2_q;
  logic [7:0]  x2_q;
  logic [7:0]  p2_q;
  logic        last2_q;
  // stage 3 / output
  logic [8:0]  idx3_q;
  logic [23:0] col3_q;
  logic [7:0]  bri3_q;
  logic        last3_q;

  logic [11:0] num1_d;
  logic [16:0] hue_inv;
  logic [23:0] x_prod;
  logic [8:0]  shift;
  logic [8:0]  sum;
  logic [7:0]  a_wrap;
  logic [7:0]  a_fin;

  assign adv_o = !(v3_q && out_stall_i);

  // 2*j*len + cnt, numerator of the rounded pulse shift
  assign num1_d = {tok_i.pulse, 1'b0} * {4'd0, cfg_i.row_length} +
                  {8'd0, cfg_i.pulse_count};
  assign hue_inv = 17'h10000 - {1'b0, hue1_q};
  assign x_prod  = 24'(hue_inv) * 24'd255;
  assign shift   = prod2_q[25:17];
  assign sum     = {1'b0, p2_q} + shift;
  assign a_wrap  = (sum >= {1'b0, cfg_i.row_length}) ?
                   8'(sum - {1'b0, cfg_i.row_length}) : sum[7:0];
  assign a_fin   = cfg_i.reverse ? (cfg_i.row_length - 8'd1 - a_wrap) : a_wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_o) begin
      v1_q <= tok_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      num1_q  <= num1_d;
      hue1_q  <= cfg_i.start_hue + tok_i.hue_off;
      p1_q    <= tok_i.pos;
      last1_q <= tok_i.last;

      prod2_q <= 29'(num1_q) * 29'(chw_pkg::pulse_recip(cfg_i.pulse_count));
      x2_q    <= x_prod[23:16];
      p2_q    <= p1_q;
      last2_q <= last1_q;

      idx3_q  <= 9'(chw_pkg::ROW_START) + {1'b0, a_fin};
      col3_q  <= chw_pkg::wheel(x2_q);
      bri3_q  <= cfg_i.brightness;
      last3_q <= last2_q;
    end
  end

  assign out_valid_o        = v3_q;
  assign pixel_index_o      = idx3_q;
  assign pixel_color_o      = col3_q;
  assign pixel_brightness_o = bri3_q;
  assign last_o             = last3_q;

endmodule
